// ===== rtl/bdq_pkg.sv =====
// Shared types, constants and helpers for the bounded deque.
`default_nettype none
package bdq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int REQ_W      = 3;
	localparam int STS_W      = 2;
	localparam int IN_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((DATA_WIDTH + CNT_W + 7) / 8) * 8;

	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_LIST       = 3'd4;

	localparam logic [STS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EMIT_POP,
		S_EMIT_LIST
	} ctl_state_t;

	typedef struct packed {
		logic             push_front;
		logic             push_back;
		logic             pop_front;
		logic             pop_back;
		logic             list_start;
		logic             list_next;
		logic             load_result;
		logic             load_word;
		logic [STS_W-1:0] res_status;
		logic             res_last;
	} ctl_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic list_last;
		logic out_free;
	} dp_sts_t;

	function automatic logic [AW-1:0] wrap_index(input logic [CNT_W:0] s);
		logic [CNT_W:0] r;
		r = (s >= (CNT_W+1)'(DEPTH)) ? s - (CNT_W+1)'(DEPTH) : s;
		return r[AW-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/bdq_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic             re,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/bdq_ctrl.sv =====
// Request sequencer for the bounded deque.
`default_nettype none
module bdq_ctrl
	import bdq_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	input  wire logic [REQ_W-1:0] req_type,
	input  wire dp_sts_t          sts,
	output logic                  req_ready,
	output ctl_cmd_t              cmd
);

	ctl_state_t state_q, state_d;
	logic       accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == S_IDLE) && sts.out_free;
	assign accept    = req_valid && req_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.res_status = STS_OK;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req_type)
						REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
							cmd.load_result = 1'b1;
							cmd.res_last    = 1'b1;
							if (sts.full) begin
								cmd.res_status = STS_FULL;
							end else begin
								cmd.push_front = (req_type == REQ_PUSH_FRONT);
								cmd.push_back  = (req_type == REQ_PUSH_BACK);
							end
						end
						REQ_POP_FRONT, REQ_POP_BACK: begin
							if (sts.empty) begin
								cmd.load_result = 1'b1;
								cmd.res_last    = 1'b1;
								cmd.res_status  = STS_EMPTY;
							end else begin
								cmd.pop_front = (req_type == REQ_POP_FRONT);
								cmd.pop_back  = (req_type == REQ_POP_BACK);
								state_d       = S_EMIT_POP;
							end
						end
						REQ_LIST: begin
							if (sts.empty) begin
								cmd.load_result = 1'b1;
								cmd.res_last    = 1'b1;
								cmd.res_status  = STS_EMPTY;
							end else begin
								cmd.list_start = 1'b1;
								state_d        = S_EMIT_LIST;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_EMIT_POP: begin
				if (sts.out_free) begin
					cmd.load_word = 1'b1;
					cmd.res_last  = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_EMIT_LIST: begin
				if (sts.out_free) begin
					cmd.load_word = 1'b1;
					cmd.res_last  = sts.list_last;
					if (sts.list_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.list_next = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/bdq_dp.sv =====
// Datapath of the bounded deque: pointers, ring store and output register.
`default_nettype none
module bdq_dp
	import bdq_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ctl_cmd_t              cmd,
	input  wire logic [DATA_WIDTH-1:0] push_value,
	input  wire logic                  out_ready,
	output dp_sts_t                    sts,
	output logic                       out_valid,
	output logic      [DATA_WIDTH-1:0] out_data,
	output logic      [STS_W-1:0]      out_status,
	output logic                       out_last,
	output logic      [CNT_W-1:0]      out_occ
);

	logic [AW-1:0]         front_q, front_d, front_dec, addr;
	logic [CNT_W-1:0]      count_q, count_d, idx_q;
	logic                  we, re;
	logic [DATA_WIDTH-1:0] rdata;
	logic                  valid_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [STS_W-1:0]      status_q;
	logic                  last_q;
	logic [CNT_W-1:0]      occ_q;
	logic [CNT_W:0]        front_x, count_x, idx_x;

	assign front_x   = (CNT_W+1)'(front_q);
	assign count_x   = (CNT_W+1)'(count_q);
	assign idx_x     = (CNT_W+1)'(idx_q);
	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);

	always_comb begin
		addr = front_q;
		if (cmd.push_front) begin
			addr = front_dec;
		end else if (cmd.push_back) begin
			addr = wrap_index(front_x + count_x);
		end else if (cmd.pop_back) begin
			addr = wrap_index(front_x + count_x - (CNT_W+1)'(1));
		end else if (cmd.list_next) begin
			addr = wrap_index(front_x + idx_x + (CNT_W+1)'(1));
		end
	end

	assign we = cmd.push_front || cmd.push_back;
	assign re = cmd.pop_front || cmd.pop_back || cmd.list_start || cmd.list_next;

	always_comb begin
		count_d = count_q;
		front_d = front_q;
		if (we) begin
			count_d = count_q + CNT_W'(1);
		end else if (cmd.pop_front || cmd.pop_back) begin
			count_d = count_q - CNT_W'(1);
		end
		if (cmd.push_front) begin
			front_d = front_dec;
		end else if (cmd.pop_front) begin
			front_d = wrap_index(front_x + (CNT_W+1)'(1));
		end
	end

	bdq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.re    (re),
		.addr  (addr),
		.wdata (push_value),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			front_q <= front_d;
			count_q <= count_d;
			if (cmd.list_start) begin
				idx_q <= '0;
			end else if (cmd.list_next) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (cmd.load_result || cmd.load_word) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result || cmd.load_word) begin
			data_q   <= cmd.load_word ? rdata : '0;
			status_q <= cmd.res_status;
			last_q   <= cmd.res_last;
			occ_q    <= count_d;
		end
	end

	assign sts.empty     = (count_q == '0);
	assign sts.full      = (count_q == CNT_W'(DEPTH));
	assign sts.list_last = ((idx_q + CNT_W'(1)) == count_q);
	assign sts.out_free  = !valid_q || out_ready;

	assign out_valid  = valid_q;
	assign out_data   = data_q;
	assign out_status = status_q;
	assign out_last   = last_q;
	assign out_occ    = occ_q;

endmodule
`default_nettype wire

// ===== rtl/bounded_deque_with_listing.sv =====
// Bounded double-ended queue with a listing request (top level).
//
// Requests enter on the s_ channel: s_tuser carries the request kind
// (push front, push back, pop front, pop back, list), s_tdata the word to push.
// Results leave on the m_ channel: m_tuser carries the status, m_tdata the
// returned word and the occupancy after the request, m_tlast marks the final
// result of a request.
// A push, an error or an unused code is taken without leaving the idle state; a
// push or error result appears in the output register on the next cycle. A pop
// reads the ring store first and then loads the word into the output register.
// A list reads the front word first, then emits one stored word per cycle
// while m_tready stays high, the most the single-port ring store read allows.
// s_tready is high only while no request is in progress and the output
// register is empty or being drained; a new request may enter in the cycle in
// which the previous result transfers. When the receiver stalls, the result
// is held and s_tready stays low.
// Reset empties the queue and marks the output register empty; stored words are
// not cleared.
`default_nettype none
module bounded_deque_with_listing
	import bdq_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,  // push_value
	input  wire logic [REQ_W-1:0]       s_tuser,  // req_type
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic      [OUT_TDATA_W-1:0] m_tdata,  // data_word, occupancy
	output logic      [STS_W-1:0]       m_tuser,  // status_code
	output logic                        m_tlast
);

	ctl_cmd_t              cmd;
	dp_sts_t               sts;
	logic [DATA_WIDTH-1:0] out_data;
	logic [CNT_W-1:0]      out_occ;

	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_type  (s_tuser),
		.sts       (sts),
		.req_ready (s_tready),
		.cmd       (cmd)
	);

	bdq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push_value (s_tdata[DATA_WIDTH-1:0]),
		.out_ready  (m_tready),
		.sts        (sts),
		.out_valid  (m_tvalid),
		.out_data   (out_data),
		.out_status (m_tuser),
		.out_last   (m_tlast),
		.out_occ    (out_occ)
	);

	assign m_tdata = OUT_TDATA_W'({out_occ, out_data});

endmodule
`default_nettype wire

// ===== rtl/bdq_checker.sv =====
// Port-level checks for the bounded deque, bound to the top level.
`default_nettype none
module bdq_checker
	import bdq_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata,
	input wire logic [STS_W-1:0]       m_tuser,
	input wire logic                   m_tlast
);

	logic [DATA_WIDTH-1:0] word;
	logic [CNT_W-1:0]      occ;

	assign word = m_tdata[DATA_WIDTH-1:0];
	assign occ  = m_tdata[DATA_WIDTH+CNT_W-1:DATA_WIDTH];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != STS_OK) |-> m_tlast && (word == '0))
		else $error("error result not single or carries data");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STS_FULL) |-> (occ == CNT_W'(DEPTH)))
		else $error("full status with queue not full");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STS_EMPTY) |-> (occ == '0))
		else $error("empty status with queue not empty");

endmodule

bind bounded_deque_with_listing bdq_checker u_bdq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire

// ===== sim/bounded_deque_with_listing_tb.sv =====
// Self-checking testbench for the bounded deque: directed and random requests against a mirrored deque.
module bounded_deque_with_listing_tb;
	import bdq_pkg::*;

	localparam int ITEMS       = 150;
	localparam int PHASE_LEN   = 40;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [STS_W-1:0]      status;
		logic [DATA_WIDTH-1:0] word;
		logic                  last;
		logic [CNT_W-1:0]      occupancy;
	} deque_result_t;

	class deque_scoreboard;
		logic [DATA_WIDTH-1:0] slots [DEPTH];
		int front_idx;
		int held;
		int mismatches;
		deque_result_t pending_results [$];

		function new();
			front_idx = 0;
			held = 0;
			mismatches = 0;
		endfunction

		function void queue_result(logic [STS_W-1:0] status, logic [DATA_WIDTH-1:0] word,
				logic last);
			deque_result_t r;
			r.status = status;
			r.word = word;
			r.last = last;
			r.occupancy = CNT_W'(held);
			pending_results.push_back(r);
		endfunction

		function void note_request(logic [REQ_W-1:0] req, logic [DATA_WIDTH-1:0] value);
			logic [DATA_WIDTH-1:0] word;
			case (req)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (held == DEPTH) begin
					queue_result(STS_FULL, '0, 1'b1);
				end else begin
					if (req == REQ_PUSH_FRONT) begin
						front_idx = (front_idx + DEPTH - 1) % DEPTH;
						slots[front_idx] = value;
					end else begin
						slots[(front_idx + held) % DEPTH] = value;
					end
					held++;
					queue_result(STS_OK, '0, 1'b1);
				end
			end
			REQ_POP_FRONT, REQ_POP_BACK: begin
				if (held == 0) begin
					queue_result(STS_EMPTY, '0, 1'b1);
				end else begin
					if (req == REQ_POP_FRONT) begin
						word = slots[front_idx];
						front_idx = (front_idx + 1) % DEPTH;
					end else begin
						word = slots[(front_idx + held - 1) % DEPTH];
					end
					held--;
					queue_result(STS_OK, word, 1'b1);
				end
			end
			REQ_LIST: begin
				if (held == 0) begin
					queue_result(STS_EMPTY, '0, 1'b1);
				end else begin
					for (int i = 0; i < held; i++)
						queue_result(STS_OK, slots[(front_idx + i) % DEPTH], i == held - 1);
				end
			end
			default: ;
			endcase
		endfunction

		function void compare_field(string name, logic [DATA_WIDTH-1:0] want,
				logic [DATA_WIDTH-1:0] got);
			if (want !== got) begin
				mismatches++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_result(deque_result_t got);
			deque_result_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected transfer, expected none, actual status %0d data %0h last %0b occupancy %0d",
					$time, got.status, got.word, got.last, got.occupancy);
				return;
			end
			want = pending_results.pop_front();
			compare_field("status", DATA_WIDTH'(want.status), DATA_WIDTH'(got.status));
			compare_field("data", want.word, got.word);
			compare_field("last", DATA_WIDTH'(want.last), DATA_WIDTH'(got.last));
			compare_field("occupancy", DATA_WIDTH'(want.occupancy), DATA_WIDTH'(got.occupancy));
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [REQ_W-1:0]       s_tuser = REQ_LIST;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [STS_W-1:0]       m_tuser;
	logic                   m_tlast;

	bit calm = 1'b0;
	int cycles = 0;
	int requests = 0;
	deque_scoreboard sb = new();

	bounded_deque_with_listing dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 36);
	end

	always @(negedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result({m_tuser, m_tdata[DATA_WIDTH-1:0], m_tlast,
				m_tdata[DATA_WIDTH +: CNT_W]});
	end

	function automatic logic [DATA_WIDTH-1:0] pick_word();
		case ($urandom_range(9))
		0: return '0;
		1: return '1;
		2: return DATA_WIDTH'(1) << $urandom_range(DATA_WIDTH - 1);
		default: return DATA_WIDTH'({$urandom(), $urandom()});
		endcase
	endfunction

	function automatic logic [REQ_W-1:0] pick_request(int push_pct);
		if ($urandom_range(99) < 10)
			return REQ_LIST;
		if ($urandom_range(99) < push_pct)
			return $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
		return $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
	endfunction

	task automatic send_req(input logic [REQ_W-1:0] req, input logic [DATA_WIDTH-1:0] value);
		while (!calm && $urandom_range(99) < 36) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= IN_TDATA_W'(value);
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		sb.note_request(req, value);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	initial begin
		int push_pct;
		bit paused;
		paused = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		send_req(REQ_LIST, '0);
		send_req(REQ_POP_FRONT, '1);
		send_req(REQ_POP_BACK, '0);
		send_req(REQ_PUSH_FRONT, '1);
		send_req(REQ_PUSH_BACK, '0);
		for (int i = 2; i < DEPTH; i++)
			send_req(i[0] ? REQ_PUSH_FRONT : REQ_PUSH_BACK, pick_word());
		send_req(REQ_PUSH_FRONT, pick_word());
		send_req(REQ_PUSH_BACK, pick_word());
		send_req(REQ_LIST, '0);
		send_req(REQ_POP_BACK, '0);
		send_req(REQ_POP_FRONT, '0);
		for (int c = REQ_LIST + 1; c < 2 ** REQ_W; c++)
			send_req(REQ_W'(c), pick_word());
		wait_drained();

		while (requests < ITEMS) begin
			calm = (requests >= 70 && requests < 110);
			case ((requests / PHASE_LEN) % 3)
			0: push_pct = 75;
			1: push_pct = 25;
			default: push_pct = 50;
			endcase
			if ($urandom_range(99) < 4) begin
				send_req(REQ_W'($urandom_range(2 ** REQ_W - 1, REQ_LIST + 1)), pick_word());
			end else begin
				send_req(pick_request(push_pct), pick_word());
				requests++;
			end
			if (requests == 130 && !paused) begin
				wait_drained();
				paused = 1'b1;
			end
		end

		calm = 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== bounded_deque_with_listing.f =====
rtl/bdq_pkg.sv
rtl/bdq_ram.sv
rtl/bdq_ctrl.sv
rtl/bdq_dp.sv
rtl/bounded_deque_with_listing.sv
rtl/bdq_checker.sv
sim/bounded_deque_with_listing_tb.sv
